// File: sv/assert_macros.svh
// assertion helpers used by the list core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define PLIST_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define PLIST_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define PLIST_ASSERT(label, clk, rst_n, prop, msg)

`define PLIST_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// File: sv/plist_pkg.sv
package plist_pkg;

	localparam int CAPACITY   = 32;
	localparam int DATA_W     = 32;
	localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LEN_W      = $clog2(CAPACITY + 1);
	localparam int READ_IDX_W = 5;
	localparam int LEN_OUT_W  = 6;
	localparam int CMP_W      = (LEN_W > READ_IDX_W) ? LEN_W : READ_IDX_W;

	typedef enum logic [2:0] {
		CMD_INS_FRONT = 3'd0,
		CMD_INS_MID   = 3'd1,
		CMD_INS_END   = 3'd2,
		CMD_DEL_FRONT = 3'd3,
		CMD_DEL_MID   = 3'd4,
		CMD_DEL_END   = 3'd5,
		CMD_READ      = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PUT,
		S_READ,
		S_DONE
	} state_t;

endpackage

// File: sv/plist_ram.sv
module plist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/positional_list_insert_delete_core.sv
// Ordered list of up to CAPACITY signed 32-bit entries kept in one RAM. A request is
// taken when start is high and busy is low; busy then stays high until the result has
// been shown. The result appears for exactly one cycle with done high and cannot be held
// off, so the receiver must take it in that cycle. A read passes S_READ and S_DONE, a rejected or
// no-op request only S_DONE; an insert moves k entries, then writes in S_PUT; a delete moves k,
// where k is the number of entries that have to move one place: every move goes through the
// single RAM port pair, a read of the neighbor followed by a write, stepped by one shared +/-1 counter.
`include "assert_macros.svh"

module positional_list_insert_delete_core import plist_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   command,
	input  logic signed [DATA_W-1:0]     value,
	input  logic [READ_IDX_W-1:0]        read_index,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [LEN_OUT_W-1:0]         length_after,
	output logic signed [DATA_W-1:0]     read_value
);

	state_t            state_q, state_d;
	logic [LEN_W-1:0]  length_q;
	logic [LEN_W-1:0]  cur_q;
	logic [LEN_W-1:0]  limit_q;
	logic              down_q;
	logic              ins_q;
	status_t           status_q;
	logic [DATA_W-1:0] rv_q;
	logic [DATA_W-1:0] value_q;

	logic              accept;
	cmd_t              cmd;
	logic [LEN_W-1:0]  mid;
	logic [LEN_W-1:0]  last;
	logic [LEN_W-1:0]  nxt;
	logic              hit;
	logic [CMP_W-1:0]  idx_c;
	logic [CMP_W-1:0]  len_c;
	logic              full;
	logic              empty;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	assign accept = start && (state_q == S_IDLE);
	assign cmd    = cmd_t'(command);
	assign mid    = LEN_W'(({1'b0, length_q} + (LEN_W+1)'(1)) >> 1);
	assign last   = length_q - LEN_W'(1);
	assign full   = (length_q >= LEN_W'(CAPACITY));
	assign empty  = (length_q == '0);
	assign idx_c  = CMP_W'(read_index);
	assign len_c  = CMP_W'(length_q);

	// shared step unit: next shift position and end-of-shift compare
	assign nxt = down_q ? (cur_q - LEN_W'(1)) : (cur_q + LEN_W'(1));
	assign hit = (nxt == limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = (state_q != S_IDLE);
		done      = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cur_q[IDX_W-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = idx_c[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (cmd)
						CMD_INS_FRONT, CMD_INS_MID, CMD_INS_END: begin
							if (full) begin
								state_d = S_DONE;
							end else if (cmd == CMD_INS_END) begin
								state_d = S_PUT;
							end else if (cmd == CMD_INS_MID && mid == length_q) begin
								state_d = S_PUT;
							end else if (empty) begin
								state_d = S_PUT;
							end else begin
								state_d = S_SHIFT_RD;
							end
						end
						CMD_DEL_FRONT, CMD_DEL_MID, CMD_DEL_END: begin
							if (empty || cmd == CMD_DEL_END || length_q == LEN_W'(1)) begin
								state_d = S_DONE;
							end else if (cmd == CMD_DEL_MID && mid == last) begin
								state_d = S_DONE;
							end else begin
								state_d = S_SHIFT_RD;
							end
						end
						CMD_READ: begin
							state_d = (idx_c >= len_c) ? S_DONE : S_READ;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_SHIFT_RD: begin
				ram_raddr = nxt[IDX_W-1:0];
				state_d   = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				ram_we    = 1'b1;
				ram_waddr = cur_q[IDX_W-1:0];
				ram_wdata = ram_rdata;
				if (hit) begin
					state_d = ins_q ? S_PUT : S_DONE;
				end else begin
					state_d = S_SHIFT_RD;
				end
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = limit_q[IDX_W-1:0];
				ram_wdata = value_q;
				state_d   = S_DONE;
			end
			S_READ: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
		end else begin
			if (accept) begin
				// deletes that need no move finish right here
				if (!empty && (cmd == CMD_DEL_FRONT || cmd == CMD_DEL_MID
				    || cmd == CMD_DEL_END) && state_d == S_DONE) begin
					length_q <= last;
				end
			end else if (state_q == S_SHIFT_WR && hit && !ins_q) begin
				length_q <= last;
			end else if (state_q == S_PUT) begin
				length_q <= length_q + LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q  <= value;
			rv_q     <= '0;
			status_q <= ST_OK;
			unique case (cmd)
				CMD_INS_FRONT, CMD_INS_MID, CMD_INS_END: begin
					ins_q  <= 1'b1;
					down_q <= 1'b1;
					cur_q  <= length_q;
					if (full) begin
						status_q <= ST_FULL;
					end
					if (cmd == CMD_INS_FRONT) begin
						limit_q <= '0;
					end else if (cmd == CMD_INS_MID) begin
						limit_q <= mid;
					end else begin
						limit_q <= length_q;
					end
				end
				CMD_DEL_FRONT, CMD_DEL_MID, CMD_DEL_END: begin
					ins_q   <= 1'b0;
					down_q  <= 1'b0;
					limit_q <= last;
					if (empty) begin
						status_q <= ST_EMPTY;
					end
					if (cmd == CMD_DEL_MID && length_q != LEN_W'(1)) begin
						cur_q <= mid;
					end else begin
						cur_q <= '0;
					end
				end
				CMD_READ: begin
					ins_q  <= 1'b0;
					down_q <= 1'b0;
					if (idx_c >= len_c) begin
						status_q <= ST_RANGE;
					end
				end
				default: begin
					ins_q  <= 1'b0;
					down_q <= 1'b0;
				end
			endcase
		end else begin
			if (state_q == S_SHIFT_WR) begin
				cur_q <= nxt;
			end
			if (state_q == S_READ) begin
				rv_q <= ram_rdata;
			end
		end
	end

	plist_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign status       = status_q;
	assign length_after = LEN_OUT_W'(length_q);
	assign read_value   = rv_q;

	`PLIST_ASSERT(a_len_cap, clk, arst_n, length_q <= LEN_W'(CAPACITY), "length above capacity")
	`PLIST_ASSERT(a_done_idle, clk, arst_n, done |=> !busy, "done not followed by idle")
	`PLIST_ASSERT(a_accept_busy, clk, arst_n, accept |=> busy, "request taken but not busy")
	`PLIST_NEVER(a_shift_past, clk, arst_n, state_q == S_SHIFT_WR && cur_q == limit_q, "shift ran past its end")
	`PLIST_NEVER(a_put_full, clk, arst_n, state_q == S_PUT && full, "insert into full list")

endmodule
